### hw/rtl/compacting_value_list_macros.svh
// Assertion macros for the compacting value list.
// Used by the top level; assumes clk and arst_n in scope.
`ifndef COMPACTING_VALUE_LIST_MACROS_SVH
`define COMPACTING_VALUE_LIST_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CVL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("compacting_value_list: check failed in same cycle");
`define CVL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("compacting_value_list: check failed in next cycle");
`else
`define CVL_ASSERT_NOW(label, ante, cons)
`define CVL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/cvl_pkg.sv
// Shared types and constants for the compacting value list.
// No dependencies; used by cvl_ctrl, cvl_path and the top level.
package cvl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int MODE_W       = 2;
	localparam int VALUE_W      = 32;
	localparam int STATUS_W     = 2;
	localparam int POS_W        = 6;
	localparam int ENTRIES_W    = 7;

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef enum logic [2:0] {
		EM_OK,
		EM_NOTFOUND,
		EM_FULL,
		EM_EMPTY,
		EM_ELEM
	} emit_t;

	typedef struct packed {
		logic  load;
		logic  append;
		logic  match;
		logic  del;
		logic  rotate;
		logic  emit;
		emit_t kind;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic found;
		logic dump_last;
	} stat_t;

endpackage

### hw/rtl/cvl_ctrl.sv
// Controller state machine for the compacting value list.
// Depends on cvl_pkg; drives cvl_path through cmd_t and reads stat_t.
module cvl_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cvl_pkg::MODE_W-1:0]     mode,
	input  cvl_pkg::stat_t                 stat,
	output cvl_pkg::cmd_t                  cmd,
	output logic                           busy,
	output logic                           valid
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEL,
		S_DUMP
	} state_t;

	state_t                       state_q, state_d;
	logic [cvl_pkg::MODE_W-1:0]   mode_q;
	logic                         valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (mode_q)
					cvl_pkg::MODE_APPEND: begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
						if (stat.full) begin
							cmd.kind = cvl_pkg::EM_FULL;
						end else begin
							cmd.append = 1'b1;
							cmd.kind   = cvl_pkg::EM_OK;
						end
					end
					cvl_pkg::MODE_REMOVE: begin
						cmd.match = 1'b1;
						state_d   = S_DEL;
					end
					cvl_pkg::MODE_DUMP: begin
						if (stat.empty) begin
							cmd.emit = 1'b1;
							cmd.kind = cvl_pkg::EM_EMPTY;
							state_d  = S_IDLE;
						end else begin
							state_d = S_DUMP;
						end
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.kind = cvl_pkg::EM_OK;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_DEL: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
				if (stat.found) begin
					cmd.del  = 1'b1;
					cmd.kind = cvl_pkg::EM_OK;
				end else begin
					cmd.kind = cvl_pkg::EM_NOTFOUND;
				end
			end
			S_DUMP: begin
				cmd.rotate = 1'b1;
				cmd.emit   = 1'b1;
				cmd.kind   = cvl_pkg::EM_ELEM;
				if (stat.dump_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= cvl_pkg::MODE_APPEND;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= cmd.emit;
			if (cmd.load) begin
				mode_q <= mode;
			end
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign valid = valid_q;

endmodule

### hw/rtl/cvl_path.sv
// Datapath for the compacting value list: a row of entry cells with
// parallel match, shift-down delete, rotate readout and the result registers.
// Depends on cvl_pkg; commanded by cvl_ctrl.
module cvl_path #(
	parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cvl_pkg::cmd_t                       cmd,
	input  logic signed [cvl_pkg::VALUE_W-1:0]  value,
	output cvl_pkg::stat_t                      stat,
	output logic [cvl_pkg::STATUS_W-1:0]        status,
	output logic [cvl_pkg::POS_W-1:0]           position,
	output logic signed [cvl_pkg::VALUE_W-1:0]  element,
	output logic [cvl_pkg::ENTRIES_W-1:0]       entries,
	output logic                                last
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = cvl_pkg::VALUE_W;
	localparam int PW = cvl_pkg::POS_W;
	localparam int EW = cvl_pkg::ENTRIES_W;

	logic signed [VW-1:0]       cell_q [CAPACITY];
	logic signed [VW-1:0]       val_q;
	logic [CW-1:0]              count_q, count_d;
	logic [IW-1:0]              pos_q;
	logic [CAPACITY-1:0]        match_q, match_d;
	logic [CAPACITY-1:0]        shift_dn;
	logic                       dump_last;

	logic [cvl_pkg::STATUS_W-1:0] status_q;
	logic [IW-1:0]                position_q;
	logic signed [VW-1:0]         element_q;
	logic [CW-1:0]                entries_q;
	logic                         last_q;

	assign dump_last = ((CW'(pos_q) + CW'(1)) == count_q);

	always_comb begin
		count_d = count_q;
		if (cmd.append) begin
			count_d = count_q + CW'(1);
		end else if (cmd.del) begin
			count_d = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VW-1:0] nbr;
		logic                 at_count;
		logic                 at_tail;
		logic                 below_tail;

		if (i == CAPACITY - 1) begin : g_top
			assign nbr = cell_q[i];
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end

		assign at_count   = (count_q == CW'(i));
		assign at_tail    = (count_q == CW'(i + 1));
		assign below_tail = (CW'(i + 1) < count_q);
		assign match_d[i] = (cell_q[i] == val_q) && (CW'(i) < count_q);
		assign shift_dn[i] = ~|(match_q >> (i + 1));

		always_ff @(posedge clk) begin
			if (cmd.append && at_count) begin
				cell_q[i] <= val_q;
			end else if (cmd.del && shift_dn[i]) begin
				cell_q[i] <= nbr;
			end else if (cmd.rotate) begin
				if (at_tail) begin
					cell_q[i] <= cell_q[0];
				end else if (below_tail) begin
					cell_q[i] <= nbr;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			match_q <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.load) begin
				pos_q <= '0;
			end else if (cmd.rotate) begin
				pos_q <= pos_q + IW'(1);
			end
			if (cmd.match) begin
				match_q <= match_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end
		if (cmd.emit) begin
			entries_q <= count_d;
			if (cmd.kind == cvl_pkg::EM_ELEM) begin
				position_q <= pos_q;
				element_q  <= cell_q[0];
				last_q     <= dump_last;
			end else begin
				position_q <= '0;
				element_q  <= '0;
				last_q     <= 1'b1;
			end
			case (cmd.kind)
				cvl_pkg::EM_OK:       status_q <= cvl_pkg::ST_OK;
				cvl_pkg::EM_NOTFOUND: status_q <= cvl_pkg::ST_NOTFOUND;
				cvl_pkg::EM_FULL:     status_q <= cvl_pkg::ST_FULL;
				cvl_pkg::EM_EMPTY:    status_q <= cvl_pkg::ST_EMPTY;
				cvl_pkg::EM_ELEM:     status_q <= cvl_pkg::ST_OK;
				default:              status_q <= cvl_pkg::ST_OK;
			endcase
		end
	end

	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.empty     = (count_q == '0);
	assign stat.found     = |match_q;
	assign stat.dump_last = dump_last;

	assign status   = status_q;
	assign position = PW'(position_q);
	assign element  = element_q;
	assign entries  = EW'(entries_q);
	assign last     = last_q;

endmodule

### hw/rtl/compacting_value_list.sv
// Compacting value list: bounded list of signed 32-bit values in insertion order.
// Depends on cvl_pkg, cvl_ctrl, cvl_path and compacting_value_list_macros.svh.
//
// Usage:
//   Command channel: drive mode and value with start; the beat is taken at a
//   rising edge with start high and busy low. mode 0 appends, 1 removes the
//   last entry equal to value, 2 dumps the list, 3 does nothing.
//   Result channel: each result appears on status, position, element, entries and
//   last, marked by valid high for a single cycle. The receiver cannot stall, so
//   every result must be taken in the cycle it appears.
// Sequencing and throughput:
//   Append and no-op: the result is registered from the execute state; busy drops with the
//   last result, so the next command can be taken at the edge that ends it.
//   Remove: the execute state matches all cells in parallel, the delete state
//   then shifts the entries above the hit down one place.
//   Dump: after the execute state, the dump state gives one result per cycle,
//   count results in all; the cells rotate once per result and end restored.
//   An empty dump gives a single status-empty result from the execute state.
// Reset: clears the entry count and the controller; cell contents stay as is
//   and are never read until written.
module compacting_value_list #(
	parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cvl_pkg::MODE_W-1:0]          mode,
	input  logic signed [cvl_pkg::VALUE_W-1:0]  value,
	output logic                                valid,
	output logic [cvl_pkg::STATUS_W-1:0]        status,
	output logic [cvl_pkg::POS_W-1:0]           position,
	output logic signed [cvl_pkg::VALUE_W-1:0]  element,
	output logic [cvl_pkg::ENTRIES_W-1:0]       entries,
	output logic                                last
);

`include "compacting_value_list_macros.svh"

	localparam int EW = cvl_pkg::ENTRIES_W;

	cvl_pkg::cmd_t  cmd;
	cvl_pkg::stat_t stat;

	cvl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.valid  (valid)
	);

	cvl_path #(
		.CAPACITY (CAPACITY)
	) u_path (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.stat     (stat),
		.status   (status),
		.position (position),
		.element  (element),
		.entries  (entries),
		.last     (last)
	);

	`CVL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`CVL_ASSERT_NEXT(a_dump_back_to_back, valid && !last, valid)
	`CVL_ASSERT_NOW(a_full_count, valid && (status == cvl_pkg::ST_FULL), entries == EW'(CAPACITY))
	`CVL_ASSERT_NOW(a_empty_single, valid && (status == cvl_pkg::ST_EMPTY), last && (entries == '0))

endmodule
